/* hw/rtl/ev_route_feasibility_checker_macros.svh */
// Assertion macros shared by the route feasibility checker RTL.
`ifndef EV_ROUTE_FEASIBILITY_CHECKER_MACROS_SVH
`define EV_ROUTE_FEASIBILITY_CHECKER_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define EVRFC_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("evrfc: same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define EVRFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("evrfc: next-cycle check failed");

`endif

/* hw/rtl/evrfc_pkg.sv */
// Shared types, constants and helpers of the route feasibility checker.
package evrfc_pkg;

   localparam int NODES       = 128;
   localparam int NODE_W      = 7;
   localparam int IDX_W       = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int DADDR_W     = $clog2(NODES * NODES);
   localparam int DIST_W      = 24;
   localparam int DEM_W       = 16;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int LEN_W       = 32;
   localparam int CHARGE_W    = 32;
   localparam int ENERGY_W    = CSR_W + DIST_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_FIELDS_W = 2 * NODE_W + DIST_W + DEM_W + 3;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_PAD_W    = REQ_TDATA_W - REQ_FIELDS_W;
   localparam int RSP_FIELDS_W = 2 + NODE_W + 3 * LEN_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // 100000 in Q24.8
   localparam logic [LEN_W-1:0] PENALTY_Q8 = 32'd25600000;

   typedef enum logic [1:0] {
      CMD_NODE  = 2'd0,
      CMD_DIST  = 2'd1,
      CMD_ROUTE = 2'd2,
      CMD_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_FEASIBLE     = 2'd0,
      ST_LOAD_SHORT   = 2'd1,
      ST_CHARGE_SHORT = 2'd2,
      ST_PENALTY      = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BATTERY  = 2'd0,
      CSR_VEHICLE  = 2'd1,
      CSR_ENERGY   = 2'd2,
      CSR_DEPOT    = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [CSR_W-1:0]  charge_capacity;
      logic [CSR_W-1:0]  vehicle_capacity;
      logic [CSR_W-1:0]  energy_per_distance;
      logic [NODE_W-1:0] depot_node;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] other_node;
      logic [DIST_W-1:0] distance;
      logic [DEM_W-1:0]  demand;
      logic              station;
      logic              first;
      logic              last;
      logic              start_at_zero;
      logic              node_ok;
      logic              other_ok;
   } item_type;

   typedef struct packed {
      status_type        status;
      logic [NODE_W-1:0] fail_node;
      logic [LEN_W-1:0]  route_length;
      logic [LEN_W-1:0]  best_length;
      logic [LEN_W-1:0]  eval_count;
   } rsp_type;

   function automatic logic in_range(input logic [NODE_W-1:0] n);
      return 32'(n) < 32'(NODES);
   endfunction

   function automatic logic [IDX_W-1:0] node_addr(input logic [NODE_W-1:0] n);
      return IDX_W'(n);
   endfunction

   function automatic logic [DADDR_W-1:0] pair_addr(input logic [NODE_W-1:0] from,
                                                     input logic [NODE_W-1:0] to);
      return DADDR_W'(from) * DADDR_W'(NODES) + DADDR_W'(to);
   endfunction

endpackage

/* hw/rtl/ev_route_feasibility_checker.sv */
// Route feasibility checker top level: configuration registers and stream ports.
//
// Request words on req_* carry table loads (tuser = 0 node entry, 1 distance),
// route nodes (tuser = 2, tlast marks the last node of a route) and the
// best-length clear (tuser = 3). Configuration goes through csr_we, csr_index
// and csr_wdata; the user must write only while idle (the block does not check).
// Each route's last node yields one response word on rsp_* with status,
// failing node, route length, best length and evaluation count.
// An accepted word is registered in the input stage, then waits in a
// four-entry queue. The sequencer takes table loads, clears and first
// route nodes as it pops them; a later route node passes a table read,
// an energy multiply and a charge compare, and a last node then loads
// the response register. Once a route fails, its nodes skip the multiply
// and the compare.
// When rsp_tready is low the response is held and the sequencer waits at
// its report step, while the queue and input stage keep taking words.
// Reset clears the route state, the count and the registers and sets the
// best length to all ones; table contents stay undefined until loaded.
`include "ev_route_feasibility_checker_macros.svh"

module ev_route_feasibility_checker import evrfc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // node[6:0], other_node[13:7], distance[37:14], demand[53:38],
   // station[54], first[55], start_at_zero[56], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]             req_tuser,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[1:0], fail_node[8:2], route_length[40:9], best_length[72:41],
   // eval_count[104:73], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     push_valid;
   item_type push_item;
   logic     push_ready;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;
   rsp_type  rsp_word;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BATTERY: cfg_in.charge_capacity     = csr_wdata;
            CSR_VEHICLE: cfg_in.vehicle_capacity    = csr_wdata;
            CSR_ENERGY:  cfg_in.energy_per_distance = csr_wdata;
            CSR_DEPOT:   cfg_in.depot_node          = csr_wdata[NODE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   evrfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   evrfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop        (q_pop)
   );

   evrfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}},
                       rsp_word.eval_count,
                       rsp_word.best_length,
                       rsp_word.route_length,
                       rsp_word.fail_node,
                       rsp_word.status};

   `EVRFC_ASSERT_NEXT(a_battery_write, clock, reset,
      csr_we && csr_index == CSR_BATTERY, cfg_ff.charge_capacity == $past(csr_wdata))
   `EVRFC_ASSERT_NEXT(a_count_steps, clock, reset,
      rsp_tvalid && rsp_tready,
      !rsp_tvalid || rsp_tdata[104:73] == $past(rsp_tdata[104:73]) + 32'd1)
   `EVRFC_ASSERT_HOLDS(a_best_not_above, clock, reset,
      rsp_tvalid, rsp_tdata[72:41] <= rsp_tdata[40:9])

endmodule

/* hw/rtl/evrfc_front.sv */
// Input stage: accepts request words and classifies them into queue items.
module evrfc_front import evrfc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // node[6:0], other_node[13:7], distance[37:14], demand[53:38],
   // station[54], first[55], start_at_zero[56], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]             req_tuser,
   input  logic                   req_tlast,
   output logic                   push_valid,
   output item_type               push_item,
   input  logic                   push_ready
);

   logic     hold_valid_ff;
   item_type hold_ff;
   item_type hold_in;

   always_comb begin
      hold_in.kind          = kind_type'(req_tuser);
      hold_in.node          = req_tdata[NODE_W-1:0];
      hold_in.other_node    = req_tdata[2*NODE_W-1:NODE_W];
      hold_in.distance      = req_tdata[2*NODE_W+DIST_W-1:2*NODE_W];
      hold_in.demand        = req_tdata[2*NODE_W+DIST_W+DEM_W-1:2*NODE_W+DIST_W];
      hold_in.station       = req_tdata[2*NODE_W+DIST_W+DEM_W];
      hold_in.first         = req_tdata[2*NODE_W+DIST_W+DEM_W+1];
      hold_in.start_at_zero = req_tdata[2*NODE_W+DIST_W+DEM_W+2];
      hold_in.last          = req_tlast;
      hold_in.node_ok       = in_range(req_tdata[NODE_W-1:0]);
      hold_in.other_ok      = in_range(req_tdata[2*NODE_W-1:NODE_W]);
   end

   assign req_tready = !hold_valid_ff || push_ready;
   assign push_valid = hold_valid_ff;
   assign push_item  = hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_tready) begin
         hold_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         hold_ff <= hold_in;
      end
   end

endmodule

/* hw/rtl/evrfc_queue.sv */
// Short item queue between the input stage and the route sequencer.
module evrfc_queue import evrfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop
);

   item_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hw/rtl/evrfc_back.sv */
// Route sequencer: node and distance tables, leg checks and result register.
module evrfc_back import evrfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output rsp_type  rsp_word
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_ENERGY,
      S_REPORT
   } state_type;

   state_type             state_ff, state_in;
   item_type              cur_ff, cur_in;
   logic [NODE_W-1:0]     prev_ff, prev_in;
   logic [DEM_W-1:0]      load_ff, load_in;
   logic [CHARGE_W-1:0]   charge_ff, charge_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   status_type            rstat_ff, rstat_in;
   logic [NODE_W-1:0]     fail_ff, fail_in;
   logic                  pen_ff, pen_in;
   logic [LEN_W-1:0]      best_ff, best_in;
   logic [LEN_W-1:0]      count_ff, count_in;
   logic [ENERGY_W-1:0]   energy_ff, energy_in;
   logic                  node_ok_ff, node_ok_in;
   logic                  dist_ok_ff, dist_ok_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   // {station, demand} per node, and one distance per ordered node pair
   logic [DEM_W:0]        node_mem [NODES];
   logic [DIST_W-1:0]     dist_mem [NODES * NODES];
   logic [DEM_W:0]        node_rd_ff;
   logic [DIST_W-1:0]     dist_rd_ff;

   logic [DEM_W-1:0]      dem_v;
   logic                  stn_v;
   logic [DIST_W-1:0]     dist_v;
   logic [LEN_W:0]        len_sum;
   logic [LEN_W-1:0]      len_sat;
   logic [CHARGE_W-1:0]   full_charge;
   logic                  at_depot;
   logic                  slot_free;
   state_type             done_state;

   assign dem_v       = node_ok_ff ? node_rd_ff[DEM_W-1:0] : '0;
   assign stn_v       = node_ok_ff ? node_rd_ff[DEM_W] : 1'b0;
   assign dist_v      = dist_ok_ff ? dist_rd_ff : '0;
   assign len_sum     = {1'b0, len_ff} + (LEN_W + 1)'(dist_v);
   assign len_sat     = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
   assign full_charge = {cfg.charge_capacity, {(CHARGE_W - CSR_W){1'b0}}};
   assign at_depot    = cur_ff.node == cfg.depot_node;
   assign slot_free   = !out_valid_ff || rsp_tready;
   assign done_state  = cur_ff.last ? S_REPORT : S_IDLE;

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_word    = out_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      load_in      = load_ff;
      charge_in    = charge_ff;
      len_in       = len_ff;
      rstat_in     = rstat_ff;
      fail_in      = fail_ff;
      pen_in       = pen_ff;
      best_in      = best_ff;
      count_in     = count_ff;
      energy_in    = energy_ff;
      node_ok_in   = node_ok_ff;
      dist_ok_in   = dist_ok_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               unique case (q_item.kind) inside
                  CMD_NODE, CMD_DIST: begin
                     // table writes happen in the memory block
                  end
                  CMD_CLEAR: begin
                     best_in = '1;
                  end
                  CMD_ROUTE: begin
                     prev_in = q_item.node;
                     if (q_item.first) begin
                        load_in   = cfg.vehicle_capacity;
                        charge_in = full_charge;
                        len_in    = q_item.start_at_zero ? '0 : PENALTY_Q8;
                        pen_in    = !q_item.start_at_zero;
                        rstat_in  = ST_FEASIBLE;
                        fail_in   = '0;
                        state_in  = q_item.last ? S_REPORT : S_IDLE;
                     end else begin
                        node_ok_in = q_item.node_ok;
                        dist_ok_in = in_range(prev_ff) && q_item.node_ok;
                        state_in   = S_READ;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            len_in = len_sat;
            if (rstat_ff != ST_FEASIBLE) begin
               state_in = done_state;
            end else if (dem_v > load_ff) begin
               rstat_in = ST_LOAD_SHORT;
               fail_in  = cur_ff.node;
               state_in = done_state;
            end else begin
               load_in   = load_ff - dem_v;
               energy_in = ENERGY_W'(cfg.energy_per_distance) * ENERGY_W'(dist_v);
               state_in  = S_ENERGY;
            end
         end
         S_ENERGY: begin
            if (energy_ff > ENERGY_W'(charge_ff)) begin
               rstat_in = ST_CHARGE_SHORT;
               fail_in  = cur_ff.node;
            end else begin
               charge_in = charge_ff - CHARGE_W'(energy_ff);
               if (at_depot) begin
                  load_in = cfg.vehicle_capacity;
               end
               if (stn_v || at_depot) begin
                  charge_in = full_charge;
               end
            end
            state_in = done_state;
         end
         S_REPORT: begin
            // hold until the result register is free
            if (slot_free) begin
               count_in            = count_ff + 1'b1;
               best_in             = (len_ff < best_ff) ? len_ff : best_ff;
               out_valid_in        = 1'b1;
               out_in.status       = (rstat_ff == ST_FEASIBLE && pen_ff) ? ST_PENALTY
                                                                         : rstat_ff;
               out_in.fail_node    = (rstat_ff != ST_FEASIBLE) ? fail_ff : '0;
               out_in.route_length = len_ff;
               out_in.best_length  = (len_ff < best_ff) ? len_ff : best_ff;
               out_in.eval_count   = count_ff + 1'b1;
               state_in            = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_ff      <= '0;
         load_ff      <= '0;
         charge_ff    <= '0;
         len_ff       <= '0;
         rstat_ff     <= ST_FEASIBLE;
         fail_ff      <= '0;
         pen_ff       <= 1'b0;
         best_ff      <= '1;
         count_ff     <= '0;
         node_ok_ff   <= 1'b0;
         dist_ok_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         load_ff      <= load_in;
         charge_ff    <= charge_in;
         len_ff       <= len_in;
         rstat_ff     <= rstat_in;
         fail_ff      <= fail_in;
         pen_ff       <= pen_in;
         best_ff      <= best_in;
         count_ff     <= count_in;
         node_ok_ff   <= node_ok_in;
         dist_ok_ff   <= dist_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      energy_ff <= energy_in;
      out_ff    <= out_in;
   end

   // Tables: written and read only on the cycle an item leaves the queue.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (q_item.kind == CMD_NODE && q_item.node_ok) begin
            node_mem[node_addr(q_item.node)] <= {q_item.station, q_item.demand};
         end
         if (q_item.kind == CMD_DIST && q_item.node_ok && q_item.other_ok) begin
            dist_mem[pair_addr(q_item.node, q_item.other_node)] <= q_item.distance;
         end
         node_rd_ff <= node_mem[node_addr(q_item.node)];
         dist_rd_ff <= dist_mem[pair_addr(prev_ff, q_item.node)];
      end
   end

endmodule
